// ----- src/sexpr_pkg.sv -----
// Shared types, codes and character-class helpers for the S-expression lexer.
// No dependencies; imported by sexpr_token_lexer_top.
`timescale 1ns / 1ps

package sexpr_pkg;

  // Width of the line number carried in a result
  localparam int unsigned LINE_OUT_W = 16;

  // Result kinds
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_TOKEN = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Token types
  localparam logic [3:0] TOK_OPEN    = 4'd0;
  localparam logic [3:0] TOK_CLOSE   = 4'd1;
  localparam logic [3:0] TOK_STRING  = 4'd2;
  localparam logic [3:0] TOK_TRUE    = 4'd3;
  localparam logic [3:0] TOK_FALSE   = 4'd4;
  localparam logic [3:0] TOK_SYMBOL  = 4'd5;
  localparam logic [3:0] TOK_INTEGER = 4'd6;
  localparam logic [3:0] TOK_REAL    = 4'd7;
  localparam logic [3:0] TOK_EOF     = 4'd8;

  // Error codes
  localparam logic ERR_OPEN_STRING  = 1'b0;
  localparam logic ERR_BAD_CONSTANT = 1'b1;

  // Constant-first-letter codes
  localparam logic [1:0] CFIRST_OTHER = 2'd0;
  localparam logic [1:0] CFIRST_T     = 2'd1;
  localparam logic [1:0] CFIRST_F     = 2'd2;

  // Characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_F  = 8'h66;

  // Lexer modes
  typedef enum logic [3:0] {
    MODE_IDLE      = 4'd0,
    MODE_COMMENT   = 4'd1,
    MODE_STRING    = 4'd2,
    MODE_ESCAPE    = 4'd3,
    MODE_CONST     = 4'd4,
    MODE_NUMBER    = 4'd5,
    MODE_SYMBOL    = 4'd6,
    MODE_EOF       = 4'd7,
    MODE_ERR_STR   = 4'd8,
    MODE_ERR_CONST = 4'd9
  } mode_e;

  // Input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } lex_in_t;

  // Output request
  typedef struct packed {
    logic [1:0]            result_kind;
    logic [7:0]            text_byte;
    logic [3:0]            token_type;
    logic                  error_code;
    logic [LINE_OUT_W-1:0] line_number;
    logic                  last_result;
  } lex_out_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) || (c == 8'h5F);
  endfunction

  function automatic logic ends_token(input logic [7:0] c);
    return is_space(c) || (c == CH_QUOTE) || (c == CH_LPAREN) ||
           (c == CH_RPAREN) || (c == CH_SEMI) || (c == CH_NUL);
  endfunction

  function automatic lex_out_t mk_res(input logic [1:0] kind, input logic [7:0] text,
                                      input logic [3:0] tok, input logic err,
                                      input logic [LINE_OUT_W-1:0] line);
    lex_out_t r;
    r.result_kind = kind;
    r.text_byte   = text;
    r.token_type  = tok;
    r.error_code  = err;
    r.line_number = line;
    r.last_result = 1'b0;
    return r;
  endfunction

endpackage

// ----- src/sexpr_token_lexer_top.sv -----
// S-expression lexer: one input byte per request, up to two results per byte.
// Depends on sexpr_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid_i/in_stall_o  | lex_in_t  (byte, end flag)
//   out     | output    | out_valid_o/out_stall_i| lex_out_t (one result)
//
// One byte is taken per cycle while in_stall_o is low; its results are written
// into a 4-entry result queue as it is taken. Results leave the queue at one per
// cycle while out_stall_i is low; input stalls while more than two entries are
// queued. Reset returns the lexer to idle on line one and empties the queue.
// Stalls on either side never drop or repeat a result.
`timescale 1ns / 1ps

module sexpr_token_lexer_top #(
  parameter int unsigned LINE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sexpr_pkg::lex_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sexpr_pkg::lex_out_t out_data_o
);
  import sexpr_pkg::*;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Lexer state
  mode_e                mode_q, mode_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [LINE_BITS-1:0] sline_q, sline_d;
  logic                 sdig_q, sdig_d;
  logic                 snd_q, snd_d;
  logic [1:0]           dot_q, dot_d;
  logic [1:0]           clen_q, clen_d;
  logic [1:0]           cfirst_q, cfirst_d;

  // Results of the current request
  lex_out_t   res_d [2];
  logic [1:0] push_n;

  // Result queue
  lex_out_t          q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  logic in_acc, out_acc;

  assign in_stall_o  = (cnt_q > QCNT_W'(QDEPTH - 2));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign out_data_o  = q_mem[rd_ptr_q];

  // Lexer step: next state and results for one input byte
  always_comb begin
    logic [7:0] c;
    logic       do_idle;
    logic [3:0] ntok;
    c        = in_data_i.end_of_input ? CH_SPACE : in_data_i.data_byte;
    do_idle  = 1'b0;
    ntok     = TOK_SYMBOL;
    mode_d   = mode_q;
    line_d   = line_q;
    sline_d  = sline_q;
    sdig_d   = sdig_q;
    snd_d    = snd_q;
    dot_d    = dot_q;
    clen_d   = clen_q;
    cfirst_d = cfirst_q;
    push_n   = 2'd0;
    res_d[0] = '0;
    res_d[1] = '0;

    if (mode_q == MODE_EOF) begin
      res_d[0] = mk_res(KIND_TOKEN, 8'h00, TOK_EOF, 1'b0, LINE_OUT_W'(line_q));
      push_n   = 2'd1;
    end else if (mode_q == MODE_ERR_STR) begin
      res_d[0] = mk_res(KIND_ERROR, 8'h00, 4'd0, ERR_OPEN_STRING, LINE_OUT_W'(sline_q));
      push_n   = 2'd1;
    end else if (mode_q == MODE_ERR_CONST) begin
      res_d[0] = mk_res(KIND_ERROR, 8'h00, 4'd0, ERR_BAD_CONSTANT, LINE_OUT_W'(line_q));
      push_n   = 2'd1;
    end else begin
      // Byte handling in the current mode
      unique case (mode_q)
        MODE_IDLE: do_idle = 1'b1;
        MODE_COMMENT: begin
          if (c == CH_NL) begin
            if (line_d != '1) line_d = line_d + LINE_BITS'(1);
            mode_d = MODE_IDLE;
          end
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            mode_d   = MODE_IDLE;
            res_d[0] = mk_res(KIND_TOKEN, 8'h00, TOK_STRING, 1'b0, LINE_OUT_W'(line_d));
            push_n   = 2'd1;
          end else if (c == CH_BSLASH) begin
            mode_d = MODE_ESCAPE;
          end else begin
            if ((c == CH_NL) && (line_d != '1)) line_d = line_d + LINE_BITS'(1);
            res_d[0] = mk_res(KIND_TEXT, c, 4'd0, 1'b0, LINE_OUT_W'(line_d));
            push_n   = 2'd1;
          end
        end
        MODE_ESCAPE: begin
          mode_d   = MODE_STRING;
          res_d[0] = mk_res(KIND_TEXT,
                            (c == CH_LOW_N) ? CH_NL : ((c == CH_LOW_T) ? CH_TAB : c),
                            4'd0, 1'b0, LINE_OUT_W'(line_d));
          push_n   = 2'd1;
        end
        MODE_CONST: begin
          if (is_word(c)) begin
            if (clen_q == 2'd0) begin
              cfirst_d = (c == CH_LOW_T) ? CFIRST_T :
                         ((c == CH_LOW_F) ? CFIRST_F : CFIRST_OTHER);
            end
            if (clen_q < 2'd2) clen_d = clen_q + 2'd1;
            res_d[0] = mk_res(KIND_TEXT, c, 4'd0, 1'b0, LINE_OUT_W'(line_d));
            push_n   = 2'd1;
          end else if ((clen_q == 2'd1) && (cfirst_q != CFIRST_OTHER)) begin
            mode_d   = MODE_IDLE;
            res_d[0] = mk_res(KIND_TOKEN, 8'h00,
                              (cfirst_q == CFIRST_T) ? TOK_TRUE : TOK_FALSE,
                              1'b0, LINE_OUT_W'(line_d));
            push_n   = 2'd1;
            do_idle  = 1'b1;
          end else begin
            mode_d   = MODE_ERR_CONST;
            res_d[0] = mk_res(KIND_ERROR, 8'h00, 4'd0, ERR_BAD_CONSTANT,
                              LINE_OUT_W'(line_d));
            push_n   = 2'd1;
          end
        end
        MODE_NUMBER: begin
          if (ends_token(c)) begin
            if (snd_q || !sdig_q || (dot_q > 2'd1)) ntok = TOK_SYMBOL;
            else if (dot_q == 2'd1)                 ntok = TOK_REAL;
            else                                    ntok = TOK_INTEGER;
            mode_d   = MODE_IDLE;
            res_d[0] = mk_res(KIND_TOKEN, 8'h00, ntok, 1'b0, LINE_OUT_W'(line_d));
            push_n   = 2'd1;
            do_idle  = 1'b1;
          end else begin
            if (is_digit(c))                    sdig_d = 1'b1;
            else if (c == CH_DOT) begin
              if (dot_q < 2'd2) dot_d = dot_q + 2'd1;
            end else if (is_word(c))            snd_d = 1'b1;
            res_d[0] = mk_res(KIND_TEXT, c, 4'd0, 1'b0, LINE_OUT_W'(line_d));
            push_n   = 2'd1;
          end
        end
        MODE_SYMBOL: begin
          if (ends_token(c)) begin
            mode_d   = MODE_IDLE;
            res_d[0] = mk_res(KIND_TOKEN, 8'h00, TOK_SYMBOL, 1'b0, LINE_OUT_W'(line_d));
            push_n   = 2'd1;
            do_idle  = 1'b1;
          end else begin
            res_d[0] = mk_res(KIND_TEXT, c, 4'd0, 1'b0, LINE_OUT_W'(line_d));
            push_n   = 2'd1;
          end
        end
        default: mode_d = MODE_IDLE;
      endcase

      // Byte seen between tokens (also the byte that ended a token)
      if (do_idle) begin
        priority if (is_space(c)) begin
          if ((c == CH_NL) && (line_d != '1)) line_d = line_d + LINE_BITS'(1);
        end else if (c == CH_SEMI) begin
          mode_d = MODE_COMMENT;
        end else if ((c == CH_LPAREN) || (c == CH_RPAREN)) begin
          res_d[push_n[0]] = mk_res(KIND_TOKEN, 8'h00,
                                    (c == CH_LPAREN) ? TOK_OPEN : TOK_CLOSE,
                                    1'b0, LINE_OUT_W'(line_d));
          push_n = push_n + 2'd1;
        end else if (c == CH_QUOTE) begin
          mode_d  = MODE_STRING;
          sline_d = line_d;
        end else if (c == CH_HASH) begin
          mode_d   = MODE_CONST;
          clen_d   = 2'd0;
          cfirst_d = CFIRST_OTHER;
        end else if (is_digit(c) || (c == CH_MINUS) || (c == CH_DOT)) begin
          mode_d = MODE_NUMBER;
          sdig_d = is_digit(c);
          snd_d  = 1'b0;
          dot_d  = (c == CH_DOT) ? 2'd1 : 2'd0;
          res_d[push_n[0]] = mk_res(KIND_TEXT, c, 4'd0, 1'b0, LINE_OUT_W'(line_d));
          push_n = push_n + 2'd1;
        end else begin
          mode_d = MODE_SYMBOL;
          res_d[push_n[0]] = mk_res(KIND_TEXT, c, 4'd0, 1'b0, LINE_OUT_W'(line_d));
          push_n = push_n + 2'd1;
        end
      end

      // End of input after the virtual space
      if (in_data_i.end_of_input) begin
        if ((mode_d == MODE_STRING) || (mode_d == MODE_ESCAPE)) begin
          mode_d = MODE_ERR_STR;
          res_d[push_n[0]] = mk_res(KIND_ERROR, 8'h00, 4'd0, ERR_OPEN_STRING,
                                    LINE_OUT_W'(sline_d));
          push_n = push_n + 2'd1;
        end else if (mode_d != MODE_ERR_CONST) begin
          mode_d = MODE_EOF;
          res_d[push_n[0]] = mk_res(KIND_TOKEN, 8'h00, TOK_EOF, 1'b0,
                                    LINE_OUT_W'(line_d));
          push_n = push_n + 2'd1;
        end
      end
    end

    // Mark the final result of this byte
    if (push_n == 2'd1) res_d[0].last_result = 1'b1;
    if (push_n == 2'd2) res_d[1].last_result = 1'b1;
  end

  // Lexer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      line_q   <= LINE_BITS'(1);
      sline_q  <= LINE_BITS'(1);
      sdig_q   <= 1'b0;
      snd_q    <= 1'b0;
      dot_q    <= 2'd0;
      clen_q   <= 2'd0;
      cfirst_q <= CFIRST_OTHER;
    end else if (in_acc) begin
      mode_q   <= mode_d;
      line_q   <= line_d;
      sline_q  <= sline_d;
      sdig_q   <= sdig_d;
      snd_q    <= snd_d;
      dot_q    <= dot_d;
      clen_q   <= clen_d;
      cfirst_q <= cfirst_d;
    end
  end

  // Result queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_acc) wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
      if (out_acc) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      cnt_q <= cnt_q + (in_acc ? QCNT_W'(push_n) : '0) - (out_acc ? QCNT_W'(1) : '0);
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (in_acc && (push_n != 2'd0)) q_mem[wr_ptr_q] <= res_d[0];
    if (in_acc && (push_n == 2'd2)) q_mem[wr_ptr_q + QPTR_W'(1)] <= res_d[1];
  end

`ifndef SYNTHESIS
  // Queue never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  // EOF is terminal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   mode_q == MODE_EOF |=> mode_q == MODE_EOF)
    else $error("left EOF mode");

  // Sticky constant error repeats one error result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_acc && mode_q == MODE_ERR_CONST) |->
                   (push_n == 2'd1 && res_d[0].result_kind == KIND_ERROR))
    else $error("sticky error not repeated");

  // Line count never goes back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ##1 line_q >= $past(line_q))
    else $error("line count decreased");

  // A byte that makes two results marks only its second one as last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push_n == 2'd2) |-> (!res_d[0].last_result && res_d[1].last_result))
    else $error("last_result misplaced");
`endif

endmodule

// ----- bench/sexpr_token_lexer_top_test.sv -----
// Self-checking bench for sexpr_token_lexer_top: random S-expression byte streams,
// predicted results checked in order. Depends on sexpr_pkg and sexpr_token_lexer_top.
`timescale 1ns / 1ps

module sexpr_token_lexer_top_test;
  import sexpr_pkg::*;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  lex_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  lex_out_t out_data_o;

  sexpr_token_lexer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Byte stream waiting to be sent, and results still owed by the lexer
  lex_in_t     pending_reqs[$];
  lex_out_t    expected_results[$];
  bit          offer_taken    = 1'b0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  int unsigned mismatch_cnt   = 0;

  // Opening stream: constants, comment, escapes, numbers, NUL and 0xFF symbol text,
  // and a byte that both ends a symbol and opens a list
  logic [7:0] opening_text [25] = '{
    CH_LPAREN, CH_HASH, CH_LOW_T, CH_SPACE, CH_HASH, CH_LOW_F, CH_RPAREN, CH_SEMI,
    CH_NL, CH_QUOTE, CH_BSLASH, CH_LOW_N, CH_BSLASH, "q", CH_QUOTE, CH_MINUS, "7",
    CH_SPACE, CH_DOT, "5", CH_TAB, CH_NUL, 8'hFF, CH_LPAREN, CH_NL
  };

  // ---------------------------------------------------------------------------
  // Lexer prediction
  // ---------------------------------------------------------------------------
  mode_e       lx_mode     = MODE_IDLE;
  logic [15:0] line_cnt    = 16'd1;
  logic [15:0] str_line    = 16'd1;
  logic        seen_num    = 1'b0;
  logic        seen_alpha  = 1'b0;
  logic [1:0]  dots        = 2'd0;
  logic [1:0]  const_len   = 2'd0;
  logic [1:0]  const_first = CFIRST_OTHER;
  lex_out_t    step_out[$];

  function automatic bit is_blank(logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic bit is_ident_char(logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], 8'h5F};
  endfunction

  function automatic bit is_delim(logic [7:0] c);
    return is_blank(c) || (c inside {CH_QUOTE, CH_LPAREN, CH_RPAREN, CH_SEMI, CH_NUL});
  endfunction

  // at most two results per byte
  function automatic void add_result(logic [1:0] kind, logic [7:0] text, logic [3:0] tok,
                                     logic err, logic [15:0] line);
    lex_out_t r;
    if (step_out.size() >= 2) return;
    r.result_kind = kind;
    r.text_byte   = text;
    r.token_type  = tok;
    r.error_code  = err;
    r.line_number = line;
    r.last_result = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void add_text(logic [7:0] c);
    add_result(KIND_TEXT, c, '0, 1'b0, line_cnt);
  endfunction

  function automatic void add_token(logic [3:0] tok);
    add_result(KIND_TOKEN, '0, tok, 1'b0, line_cnt);
  endfunction

  // string errors report the line where the string opened
  function automatic void add_error();
    if (lx_mode == MODE_ERR_STR) add_result(KIND_ERROR, '0, '0, ERR_OPEN_STRING, str_line);
    else add_result(KIND_ERROR, '0, '0, ERR_BAD_CONSTANT, line_cnt);
  endfunction

  function automatic void bump_line();
    if (line_cnt != '1) line_cnt = line_cnt + 16'd1;
  endfunction

  function automatic void track_number(logic [7:0] c);
    if (is_numeral(c)) seen_num = 1'b1;
    else if (c == CH_DOT) begin
      if (dots < 2'd2) dots = dots + 2'd1;
    end else if (is_ident_char(c)) seen_alpha = 1'b1;
  endfunction

  // byte seen between tokens
  function automatic void start_token(logic [7:0] c);
    if (is_blank(c)) begin
      if (c == CH_NL) bump_line();
    end else if (c == CH_SEMI) begin
      lx_mode = MODE_COMMENT;
    end else if (c == CH_LPAREN) begin
      add_token(TOK_OPEN);
    end else if (c == CH_RPAREN) begin
      add_token(TOK_CLOSE);
    end else if (c == CH_QUOTE) begin
      lx_mode  = MODE_STRING;
      str_line = line_cnt;
    end else if (c == CH_HASH) begin
      lx_mode     = MODE_CONST;
      const_len   = 2'd0;
      const_first = CFIRST_OTHER;
    end else if (is_numeral(c) || c == CH_MINUS || c == CH_DOT) begin
      lx_mode    = MODE_NUMBER;
      seen_num   = 1'b0;
      seen_alpha = 1'b0;
      dots       = 2'd0;
      track_number(c);
      add_text(c);
    end else begin
      lx_mode = MODE_SYMBOL;
      add_text(c);
    end
  endfunction

  function automatic void lex_char(logic [7:0] c);
    logic [3:0] tok;
    logic [7:0] ch;
    case (lx_mode)
      MODE_IDLE: start_token(c);
      MODE_COMMENT: begin
        if (c == CH_NL) begin
          bump_line();
          lx_mode = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (c == CH_QUOTE) begin
          lx_mode = MODE_IDLE;
          add_token(TOK_STRING);
        end else if (c == CH_BSLASH) begin
          lx_mode = MODE_ESCAPE;
        end else begin
          if (c == CH_NL) bump_line();
          add_text(c);
        end
      end
      // escaped newline is text only, no line count
      MODE_ESCAPE: begin
        ch = c;
        if (c == CH_LOW_N) ch = CH_NL;
        else if (c == CH_LOW_T) ch = CH_TAB;
        lx_mode = MODE_STRING;
        add_text(ch);
      end
      MODE_CONST: begin
        if (is_ident_char(c)) begin
          if (const_len == 2'd0)
            const_first = (c == CH_LOW_T) ? CFIRST_T : ((c == CH_LOW_F) ? CFIRST_F : CFIRST_OTHER);
          if (const_len < 2'd2) const_len = const_len + 2'd1;
          add_text(c);
        end else if (const_len == 2'd1 && const_first != CFIRST_OTHER) begin
          lx_mode = MODE_IDLE;
          add_token((const_first == CFIRST_T) ? TOK_TRUE : TOK_FALSE);
          start_token(c);
        end else begin
          lx_mode = MODE_ERR_CONST;
          add_error();
        end
      end
      MODE_NUMBER: begin
        if (is_delim(c)) begin
          if (seen_alpha || !seen_num || dots > 2'd1) tok = TOK_SYMBOL;
          else if (dots == 2'd1) tok = TOK_REAL;
          else tok = TOK_INTEGER;
          lx_mode = MODE_IDLE;
          add_token(tok);
          start_token(c);
        end else begin
          track_number(c);
          add_text(c);
        end
      end
      MODE_SYMBOL: begin
        if (is_delim(c)) begin
          lx_mode = MODE_IDLE;
          add_token(TOK_SYMBOL);
          start_token(c);
        end else begin
          add_text(c);
        end
      end
      default: ;
    endcase
  endfunction

  // One accepted request: queue the results it should produce
  function automatic void lex_expect(lex_in_t req);
    lex_out_t r;
    step_out.delete();
    if (lx_mode == MODE_EOF) begin
      add_token(TOK_EOF);
    end else if (lx_mode == MODE_ERR_STR || lx_mode == MODE_ERR_CONST) begin
      add_error();
    end else if (!req.end_of_input) begin
      lex_char(req.data_byte);
    end else begin
      // end of input: a trailing space, then EOF or an open-string error unless a constant error stands
      lex_char(CH_SPACE);
      if (lx_mode == MODE_STRING || lx_mode == MODE_ESCAPE) begin
        lx_mode = MODE_ERR_STR;
        add_error();
      end else if (lx_mode != MODE_ERR_CONST) begin
        lx_mode = MODE_EOF;
        add_token(TOK_EOF);
      end
    end
    if (step_out.size() != 0) begin
      r = step_out.pop_back();
      r.last_result = 1'b1;
      step_out.push_back(r);
    end
    foreach (step_out[i]) expected_results.push_back(step_out[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stream generation: every unit leaves the lexer between tokens
  // ---------------------------------------------------------------------------
  function automatic void push_req(logic [7:0] b, logic eoi);
    lex_in_t r;
    r.data_byte    = b;
    r.end_of_input = eoi;
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [7:0] pick_blank();
    int unsigned k;
    k = $urandom_range(5);
    return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] pick_letter();
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    do b = 8'($urandom); while (is_delim(b));
    return b;
  endfunction

  function automatic void push_comment();
    logic [7:0] b;
    push_req(CH_SEMI, 1'b0);
    repeat ($urandom_range(5)) begin
      b = 8'($urandom);
      if (b == CH_NL) b = CH_SPACE;
      push_req(b, 1'b0);
    end
    push_req(CH_NL, 1'b0);
  endfunction

  function automatic void push_string();
    logic [7:0] b;
    push_req(CH_QUOTE, 1'b0);
    repeat ($urandom_range(6)) begin
      if ($urandom_range(4) == 0) begin
        push_req(CH_BSLASH, 1'b0);
        case ($urandom_range(4))
          0: b = CH_LOW_N;
          1: b = CH_LOW_T;
          2: b = CH_QUOTE;
          3: b = CH_BSLASH;
          default: b = 8'($urandom);
        endcase
      end else begin
        b = 8'($urandom);
        if (b == CH_QUOTE || b == CH_BSLASH) b = CH_NL;
      end
      push_req(b, 1'b0);
    end
    push_req(CH_QUOTE, 1'b0);
  endfunction

  // byte that ends a number, symbol or constant, then whatever it starts
  function automatic void push_break();
    case ($urandom_range(7))
      0, 1, 2: push_req(pick_blank(), 1'b0);
      3: push_req(CH_LPAREN, 1'b0);
      4: push_req(CH_RPAREN, 1'b0);
      5: begin
        push_req(CH_NUL, 1'b0);
        push_req(pick_blank(), 1'b0);
      end
      6: push_comment();
      default: push_string();
    endcase
  endfunction

  function automatic void push_unit();
    logic [7:0] b;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) push_req(CH_LPAREN, 1'b0);
    else if (pick < 20) push_req(CH_RPAREN, 1'b0);
    else if (pick < 30) push_req(pick_blank(), 1'b0);
    else if (pick < 37) push_comment();
    else if (pick < 50) push_string();
    else if (pick < 58) begin
      // #t or #f
      push_req(CH_HASH, 1'b0);
      push_req($urandom_range(1) ? CH_LOW_T : CH_LOW_F, 1'b0);
      push_break();
    end else if (pick < 75) begin
      if ($urandom_range(1)) begin
        // well-formed integer or real
        if ($urandom_range(2) == 0) push_req(CH_MINUS, 1'b0);
        repeat ($urandom_range(1, 4)) push_req(pick_digit(), 1'b0);
        if ($urandom_range(1)) begin
          push_req(CH_DOT, 1'b0);
          repeat ($urandom_range(3)) push_req(pick_digit(), 1'b0);
        end
      end else begin
        case ($urandom_range(2))
          0: b = pick_digit();
          1: b = CH_MINUS;
          default: b = CH_DOT;
        endcase
        push_req(b, 1'b0);
        repeat ($urandom_range(4)) begin
          case ($urandom_range(3))
            0: b = pick_digit();
            1: b = CH_DOT;
            2: b = pick_letter();
            default: b = pick_plain();
          endcase
          push_req(b, 1'b0);
        end
      end
      push_break();
    end else if (pick < 90) begin
      // symbol: any byte that starts nothing else, NUL included
      do b = 8'($urandom);
      while (is_blank(b) || is_numeral(b) ||
             (b inside {CH_SEMI, CH_LPAREN, CH_RPAREN, CH_QUOTE, CH_HASH, CH_MINUS, CH_DOT}));
      push_req(b, 1'b0);
      repeat ($urandom_range(4)) push_req($urandom_range(1) ? pick_letter() : pick_plain(), 1'b0);
      push_break();
    end else begin
      // loose byte, then a blank
      do b = 8'($urandom); while (b inside {CH_HASH, CH_QUOTE, CH_SEMI});
      push_req(b, 1'b0);
      push_req(pick_blank(), 1'b0);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------
  // acceptance at the rising edge feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      lex_expect(in_data_i);
      void'(pending_reqs.pop_front());
      offer_taken = 1'b1;
    end
  end

  // new request offered at the falling edge; an unaccepted one is held
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || offer_taken) begin
      offer_taken = 1'b0;
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_reqs[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: stall and checking
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left = hold_left - 1;
  end

  always @(negedge clk_i) begin
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  function automatic string res_str(lex_out_t r);
    return $sformatf("kind %0d text %02h tok %0d err %0d line %0d last %0d",
                     r.result_kind, r.text_byte, r.token_type, r.error_code,
                     r.line_number, r.last_result);
  endfunction

  always @(posedge clk_i) begin
    lex_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result: %s", res_str(out_data_o));
      end else begin
        want = expected_results.pop_front();
        if (out_data_o !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected %s, got %s", res_str(want), res_str(out_data_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    foreach (opening_text[i]) push_req(opening_text[i], 1'b0);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // idling profiles: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 73 : ((ph == 3) ? 33 : 0);
      recv_stall_pct = (ph == 2) ? 73 : ((ph == 3) ? 33 : 0);
      while (pending_reqs.size() < 360) push_unit();
      if (ph == 0) begin
        // long receiver hold-off while requests keep coming
        while (pending_reqs.size() > 250) @(posedge clk_i);
        @(negedge clk_i);
        hold_left = 150;
      end
      while (pending_reqs.size() != 0) @(posedge clk_i);
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // stream end: plain EOF, open string, or bad constant
    case ($urandom_range(2))
      0: begin
        case ($urandom_range(4))
          0: ;
          1: begin
            push_req(CH_HASH, 1'b0);
            push_req(CH_LOW_T, 1'b0);
          end
          2: push_req(pick_digit(), 1'b0);
          3: push_req(pick_letter(), 1'b0);
          default: push_req(CH_SEMI, 1'b0);
        endcase
        push_req(8'($urandom), 1'b1);
      end
      1: begin
        push_req(CH_QUOTE, 1'b0);
        repeat ($urandom_range(3)) push_req(pick_letter(), 1'b0);
        if ($urandom_range(1)) push_req(CH_BSLASH, 1'b0);
        push_req(8'($urandom), 1'b1);
      end
      default: begin
        push_req(CH_HASH, 1'b0);
        case ($urandom_range(3))
          0: push_req(8'($urandom), 1'b1);
          1: begin
            push_req("x", 1'b0);
            push_req(CH_SPACE, 1'b0);
          end
          2: begin
            push_req(CH_LOW_T, 1'b0);
            push_req(CH_LOW_T, 1'b0);
            push_req(CH_RPAREN, 1'b0);
          end
          default: begin
            push_req(CH_LOW_F, 1'b0);
            push_req("1", 1'b0);
            push_req(8'($urandom), 1'b1);
          end
        endcase
      end
    endcase
    // everything after the end repeats the final result
    repeat (12) push_req(8'($urandom), 1'($urandom));

    while (pending_reqs.size() != 0) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sexpr_token_lexer_top.f -----
src/sexpr_pkg.sv
src/sexpr_token_lexer_top.sv
bench/sexpr_token_lexer_top_test.sv
